### rtl/imp_pkg.sv
// ----------------------------------------------------------------------------
// imp_pkg: shared types and constants of the inertial motion profile
// Fixed-point format, epsilon, register indexes and divider status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DT_BITS   = 16;
    localparam int EPS_INT   = ((1 << FRAC_BITS) + 5000) / 10000;

    localparam logic [30:0] EPS = 31'(EPS_INT);
    localparam logic [30:0] ONE = 31'(1 << FRAC_BITS);

    localparam logic [1:0] REG_MAX_SPEED  = 2'd0;
    localparam logic [1:0] REG_ACCEL_RATE = 2'd1;
    localparam logic [1:0] REG_DECEL_RATE = 2'd2;

    typedef struct packed {
        logic done;
        logic overflow;
    } div_stat_t;

endpackage

`default_nettype wire

### rtl/inertial_motion_profile.sv
// ----------------------------------------------------------------------------
// inertial_motion_profile: single-axis trapezoidal motion profile, Q16.16
// Moves position and signed speed toward each target under accel, decel
// and speed limits; one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
// Path: PREP goes straight to braking, or first through SQUARE, TRAVEL,
//   DIVIDE and COMPARE when the stopping distance is evaluated; the
//   32-step divider sets the long path. One word in flight; the next
//   word is accepted once the result sits in the output register.
// Reset: position and speed clear to zero, limits reset to 1.0.
`timescale 1ns / 1ps
`default_nettype none

module inertial_motion_profile
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [30:0] cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // target[31:0], time_step[47:32]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [63:0] m_axis_tdata    // position[31:0], velocity[63:32]
);

    typedef enum logic [13:0] {
        ST_IDLE      = 14'b00000000000001,
        ST_PREP      = 14'b00000000000010,
        ST_SQUARE    = 14'b00000000000100,
        ST_TRAVEL    = 14'b00000000001000,
        ST_DIVIDE    = 14'b00000000010000,
        ST_COMPARE   = 14'b00000000100000,
        ST_ACCEL_MUL = 14'b00000001000000,
        ST_ACCEL_ADD = 14'b00000010000000,
        ST_BRAKE_MUL = 14'b00000100000000,
        ST_BRAKE_SUB = 14'b00001000000000,
        ST_LIMIT     = 14'b00010000000000,
        ST_POS_MUL   = 14'b00100000000000,
        ST_POS_ADD   = 14'b01000000000000,
        ST_OUTPUT    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [30:0]        max_speed_reg, max_speed_next;
    logic [30:0]        accel_rate_reg, accel_rate_next;
    logic [30:0]        decel_rate_reg, decel_rate_next;
    logic [31:0]        pos_reg, pos_next;
    logic [31:0]        speed_reg, speed_next;
    logic               out_valid_reg, out_valid_next;

    logic [31:0]        target_reg, target_next;
    logic [15:0]        dt_reg, dt_next;
    logic [31:0]        dist_reg, dist_next;
    logic               mdir_reg, mdir_next;
    logic [30:0]        abs_reg, abs_next;
    logic [30:0]        capped_reg, capped_next;
    logic signed [32:0] nabs_reg, nabs_next;
    logic [30:0]        mag_reg, mag_next;
    logic [61:0]        prod_reg, prod_next;
    logic [63:0]        out_data_reg, out_data_next;

    logic [30:0]        mul_a;
    logic [30:0]        mul_b;
    logic               mul_en;

    logic [32:0]        diff;
    logic [32:0]        neg_diff;
    logic               tgt_ahead;
    logic [31:0]        dist_calc;
    logic [31:0]        spd_abs;
    logic               spd_idle;
    logic               mdir_calc;
    logic [30:0]        abs_calc;
    logic [30:0]        decel_eff;
    logic [30:0]        dt_term;
    logic [32:0]        dts;
    logic               room;
    logic [31:0]        slack;
    logic [30:0]        capped_calc;
    logic signed [32:0] speed_up;
    logic signed [32:0] slow_down;
    logic signed [32:0] max_ext;
    logic signed [32:0] eps_ext;
    logic signed [32:0] limited;
    logic [30:0]        mag_calc;
    logic signed [32:0] pos_ext;
    logic signed [32:0] step_ext;
    logic signed [32:0] pos_sum;
    logic [31:0]        pos_final;
    logic [31:0]        speed_final;
    logic               div_start;
    logic [31:0]        quotient;
    imp_pkg::div_stat_t div_stat;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign diff      = {target_reg[31], target_reg} - {pos_reg[31], pos_reg};
    assign neg_diff  = '0 - diff;
    assign tgt_ahead = !diff[32] && (diff != '0);
    assign dist_calc = tgt_ahead ? diff[31:0] : neg_diff[31:0];
    assign spd_abs   = speed_reg[31] ? (~speed_reg + 32'd1) : speed_reg;
    assign spd_idle  = (spd_abs[30:0] <= imp_pkg::EPS);
    assign mdir_calc = spd_idle ? tgt_ahead : !speed_reg[31];
    assign abs_calc  = spd_idle ? '0 : spd_abs[30:0];

    assign decel_eff = (decel_rate_reg == '0) ? 31'd1 : decel_rate_reg;
    assign dt_term   = prod_reg[imp_pkg::DT_BITS + 30:imp_pkg::DT_BITS];

    assign dts         = {1'b0, quotient} + {2'b00, dt_term};
    assign room        = !div_stat.overflow && ({1'b0, dist_reg} > dts);
    assign slack       = dist_reg - dts[31:0];
    assign capped_calc = ({1'b0, accel_rate_reg} < slack) ? accel_rate_reg : slack[30:0];

    assign speed_up  = (dt_term > imp_pkg::EPS) ? ({2'b00, abs_reg} + {2'b00, dt_term})
                                                : {2'b00, abs_reg};
    assign slow_down = {2'b00, abs_reg} - {2'b00, dt_term};

    assign max_ext  = {2'b00, max_speed_reg};
    assign eps_ext  = {2'b00, imp_pkg::EPS};
    assign limited  = (nabs_reg > max_ext) ? max_ext : nabs_reg;
    assign mag_calc = (limited <= eps_ext) ? '0 : limited[30:0];

    assign pos_ext  = {pos_reg[31], pos_reg};
    assign step_ext = {2'b00, dt_term};
    assign pos_sum  = mdir_reg ? (pos_ext + step_ext) : (pos_ext - step_ext);

    always_comb
    begin
        priority if (!pos_sum[32] && pos_sum[31])
            pos_final = 32'h7FFF_FFFF;
        else if (pos_sum[32] && !pos_sum[31])
            pos_final = 32'h8000_0000;
        else
            pos_final = pos_sum[31:0];
    end

    assign speed_final = mdir_reg ? {1'b0, mag_reg} : ('0 - {1'b0, mag_reg});

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = abs_reg;
        mul_b  = {15'd0, dt_reg};
        unique case (state_reg)
            ST_SQUARE:
            begin
                mul_a = abs_reg;
                mul_b = abs_reg;
            end
            ST_TRAVEL:    mul_a = abs_reg;
            ST_ACCEL_MUL: mul_a = capped_reg;
            ST_BRAKE_MUL: mul_a = decel_eff;
            ST_POS_MUL:   mul_a = mag_reg;
            default:      mul_en = 1'b0;
        endcase
    end

    assign prod_next = mul_en ? ({31'd0, mul_a} * {31'd0, mul_b}) : prod_reg;
    assign div_start = (state_reg == ST_TRAVEL);

    imp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  ({decel_eff, 1'b0}),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb
    begin
        max_speed_next  = max_speed_reg;
        accel_rate_next = accel_rate_reg;
        decel_rate_next = decel_rate_reg;
        if (cfg_we)
        begin
            if (cfg_addr == imp_pkg::REG_MAX_SPEED)
                max_speed_next = cfg_wdata;
            if (cfg_addr == imp_pkg::REG_ACCEL_RATE)
                accel_rate_next = cfg_wdata;
            if (cfg_addr == imp_pkg::REG_DECEL_RATE)
                decel_rate_next = cfg_wdata;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        speed_next     = speed_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        target_next    = target_reg;
        dt_next        = dt_reg;
        dist_next      = dist_reg;
        mdir_next      = mdir_reg;
        abs_next       = abs_reg;
        capped_next    = capped_reg;
        nabs_next      = nabs_reg;
        mag_next       = mag_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    target_next = s_axis_tdata[31:0];
                    dt_next     = s_axis_tdata[47:32];
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                dist_next  = dist_calc;
                mdir_next  = mdir_calc;
                abs_next   = abs_calc;
                state_next = (tgt_ahead == mdir_calc) ? ST_SQUARE : ST_BRAKE_MUL;
            end
            ST_SQUARE:    state_next = ST_TRAVEL;
            ST_TRAVEL:    state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_stat.done)
                    state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                capped_next = capped_calc;
                state_next  = room ? ST_ACCEL_MUL : ST_BRAKE_MUL;
            end
            ST_ACCEL_MUL: state_next = ST_ACCEL_ADD;
            ST_ACCEL_ADD:
            begin
                nabs_next  = speed_up;
                state_next = ST_LIMIT;
            end
            ST_BRAKE_MUL: state_next = ST_BRAKE_SUB;
            ST_BRAKE_SUB:
            begin
                nabs_next  = slow_down;
                state_next = ST_LIMIT;
            end
            ST_LIMIT:
            begin
                mag_next   = mag_calc;
                state_next = ST_POS_MUL;
            end
            ST_POS_MUL:   state_next = ST_POS_ADD;
            ST_POS_ADD:
            begin
                pos_next   = pos_final;
                speed_next = speed_final;
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_next  = {speed_reg, pos_reg};
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            max_speed_reg  <= imp_pkg::ONE;
            accel_rate_reg <= imp_pkg::ONE;
            decel_rate_reg <= imp_pkg::ONE;
            pos_reg        <= '0;
            speed_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            max_speed_reg  <= max_speed_next;
            accel_rate_reg <= accel_rate_next;
            decel_rate_reg <= decel_rate_next;
            pos_reg        <= pos_next;
            speed_reg      <= speed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        dt_reg       <= dt_next;
        dist_reg     <= dist_next;
        mdir_reg     <= mdir_next;
        abs_reg      <= abs_next;
        capped_reg   <= capped_next;
        nabs_reg     <= nabs_next;
        mag_reg      <= mag_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

### rtl/imp_div.sv
// ----------------------------------------------------------------------------
// imp_div: restoring divider, one quotient bit per cycle
// Divides a 62-bit dividend by a 32-bit divisor into a 32-bit quotient;
// flags overflow at once when the quotient would need more bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imp_div
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [61:0]        dividend,
    input  wire logic [31:0]        divisor,
    output logic      [31:0]        quotient,
    output imp_pkg::div_stat_t      stat
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        ovf_reg, ovf_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;

    logic [32:0] trial;
    logic [32:0] trial_sub;
    logic        trial_ge;
    logic        hi_ge;

    assign trial     = {rem_reg, quo_reg[31]};
    assign trial_ge  = trial >= {1'b0, divisor};
    assign trial_sub = trial - {1'b0, divisor};
    assign hi_ge     = {2'b00, dividend[61:32]} >= divisor;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            ovf_next = hi_ge;
            if (hi_ge)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                cnt_next  = '1;
                rem_next  = {2'b00, dividend[61:32]};
                quo_next  = dividend[31:0];
            end
        end
        else if (busy_reg)
        begin
            rem_next = trial_ge ? trial_sub[31:0] : trial[31:0];
            quo_next = {quo_reg[30:0], trial_ge};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ovf_reg  <= ovf_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient      = quo_reg;
    assign stat.done     = done_reg;
    assign stat.overflow = ovf_reg;

endmodule

`default_nettype wire

### rtl/imp_checker.sv
// ----------------------------------------------------------------------------
// imp_checker: port-level checks of the inertial motion profile
// Watches the stream ports for sequencing and result range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);

    // one word in flight: ready drops right after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready stayed high after an accepted word");

    // a result never rises in the cycle after an accept
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared one cycle after accept");

    // a new result is loaded only while the input side is busy
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result loaded while idle");

    // speed magnitude is clamped to 31 bits
    a_velocity_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:32] != 32'h8000_0000)
        else $error("velocity outside its range");

    // a stalled result holds
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind inertial_motion_profile imp_checker u_imp_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### sim/tb_inertial_motion_profile.sv
// ----------------------------------------------------------------------------
// tb_inertial_motion_profile: self-checking bench for the motion profile
// Drives target/time-step words through the input stream and predicts the
// position and speed of every tick with a fixed-point model of the axis. The
// model covers the speed limit, the accel limit on the slack, braking and the
// position clamp. Results are compared in order while both stream sides
// idle at random. Directed ticks cover extreme limits and targets, the idle
// and equal-position direction rules, zero decel, dropped small gains,
// braking past zero, position clamping and the unused register index.
// Motion runs with random limits, long output stalls and noise words follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_inertial_motion_profile;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic signed [31:0] velocity;
        logic signed [31:0] position;
    } motion_t;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam longint     POS_HI     = 64'sd2147483647;
    localparam longint     POS_LO     = -64'sd2147483648;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_addr      = 2'd0;
    logic [30:0] cfg_wdata     = 31'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = 48'd0;   // target[31:0], time_step[47:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;            // position[31:0], velocity[63:32]

    logic signed [31:0] axis_pos   = 32'sd0;
    logic signed [31:0] axis_speed = 32'sd0;
    logic [30:0]        lim_speed  = imp_pkg::ONE;
    logic [30:0]        lim_accel  = imp_pkg::ONE;
    logic [30:0]        lim_decel  = imp_pkg::ONE;

    motion_t expected_motion[$];
    int      failures      = 0;
    int      burst_left    = 0;
    bit      sender_steady = 1'b0;
    int      hold_off_len  = 0;
    logic [15:0] rx_cycle  = 16'd0;

    inertial_motion_profile uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // dt in Q0.16 times v, truncated toward zero
    function automatic longint scale_by_dt(input logic [15:0] dt, input longint v);
        u64_t mag;
        u64_t p;
        mag = (v < 0) ? u64_t'(-v) : u64_t'(v);
        p   = (u64_t'(dt) * mag) >> imp_pkg::DT_BITS;
        return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic motion_t advance_axis(input logic signed [31:0] tgt,
                                             input logic [15:0] dt);
        longint  aim;
        longint  origin;
        longint  mag;
        longint  remaining;
        longint  gain;
        longint  pos;
        longint  speed;
        u64_t    decel;
        u64_t    stop_dist;
        u64_t    slack;
        u64_t    capped;
        bit      toward_pos;
        bit      heading_pos;
        motion_t r;
        aim         = longint'(tgt);
        origin      = longint'(axis_pos);
        speed       = longint'(axis_speed);
        remaining   = (aim > origin) ? aim - origin : origin - aim;
        mag         = (speed < 0) ? -speed : speed;
        toward_pos  = (aim > origin);
        heading_pos = (speed > -imp_pkg::EPS_INT);
        decel       = (lim_decel != 0) ? u64_t'(lim_decel) : 64'd1;
        if (mag <= imp_pkg::EPS_INT)
        begin
            heading_pos = toward_pos;
            mag         = 0;
        end
        if (toward_pos == heading_pos)
        begin
            stop_dist = (u64_t'(mag) * u64_t'(mag)) / (2 * decel)
                        + u64_t'(scale_by_dt(dt, mag));
            if (u64_t'(remaining) > stop_dist)
            begin
                slack  = u64_t'(remaining) - stop_dist;
                capped = (u64_t'(lim_accel) < slack) ? u64_t'(lim_accel) : slack;
                gain   = scale_by_dt(dt, longint'(capped));
                if (gain > imp_pkg::EPS_INT)
                    mag += gain;
            end
            else
                mag -= scale_by_dt(dt, longint'(decel));
        end
        else
            mag -= scale_by_dt(dt, longint'(decel));
        if (mag > longint'(lim_speed))
            mag = longint'(lim_speed);
        if (mag <= imp_pkg::EPS_INT)
            mag = 0;
        speed = heading_pos ? mag : -mag;
        pos   = origin + scale_by_dt(dt, speed);
        if (pos > POS_HI)
            pos = POS_HI;
        if (pos < POS_LO)
            pos = POS_LO;
        axis_pos   = pos[31:0];
        axis_speed = speed[31:0];
        r.position = axis_pos;
        r.velocity = axis_speed;
        return r;
    endfunction

    task automatic flag_failure(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        failures++;
        if (failures <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    always @(posedge clk)
    begin : check_result
        motion_t want;
        motion_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (expected_motion.size() == 0)
                flag_failure("unexpected word", 32'd0, got.position);
            else
            begin
                want = expected_motion.pop_front();
                if (got.position !== want.position)
                    flag_failure("position", want.position, got.position);
                if (got.velocity !== want.velocity)
                    flag_failure("velocity", want.velocity, got.velocity);
            end
        end
    end

    // output side: cycle through stall patterns, hold off on request
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 16'd1;
        if (hold_off_len > 0)
        begin
            hold_off_len  <= hold_off_len - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (rx_cycle[8:7])
                2'd0:    m_axis_tready <= 1'b1;
                2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2:    m_axis_tready <= (rx_cycle[1:0] == 2'd3);
                default: m_axis_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    task automatic send_tick(input logic [31:0] tgt, input logic [15:0] dt);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = 0;
            if (!sender_steady && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {dt, tgt};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        expected_motion.push_back(advance_axis(tgt, dt));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_motion.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [30:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            imp_pkg::REG_MAX_SPEED:  lim_speed = val;
            imp_pkg::REG_ACCEL_RATE: lim_accel = val;
            imp_pkg::REG_DECEL_RATE: lim_decel = val;
            default: ;
        endcase
    endtask

    task automatic load_limits(input logic [30:0] speed, input logic [30:0] accel,
                               input logic [30:0] decel);
        drain();
        cfg_write(imp_pkg::REG_MAX_SPEED, speed);
        cfg_write(imp_pkg::REG_ACCEL_RATE, accel);
        cfg_write(imp_pkg::REG_DECEL_RATE, decel);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] nearby_target();
        longint aim;
        if ($urandom_range(0, 15) == 0)
            return axis_pos;
        aim = longint'(axis_pos) + ($urandom_range(0, 1) ? 1 : -1)
              * longint'($urandom_range(0, 64 << 16));
        if (aim > POS_HI)
            aim = POS_HI;
        if (aim < POS_LO)
            aim = POS_LO;
        return aim[31:0];
    endfunction

    function automatic logic [30:0] pick_limit(input int kind);
        case (kind)
            0: return 31'($urandom_range(1, 64)) << 16;
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return 31'd0;
                    1:       return 31'd1;
                    2:       return 31'h7FFFFFFF;
                    default: return 31'($urandom);
                endcase
            end
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic run_profile(input int n_ticks);
        int          sent;
        int          run_len;
        int          base_dt;
        int          k;
        logic [31:0] aim;
        logic [15:0] dt;
        sent = 0;
        while (sent < n_ticks)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_tick($urandom, 16'($urandom));
                sent++;
            end
            else
            begin
                aim     = nearby_target();
                run_len = $urandom_range(4, 24);
                base_dt = $urandom_range(16'h0400, 16'h4000);
                for (k = 0; k < run_len; k++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        aim = nearby_target();
                    case ($urandom_range(0, 19))
                        0:       dt = 16'h0000;
                        1:       dt = 16'hFFFF;
                        default: dt = 16'(base_dt + $urandom_range(0, 255));
                    endcase
                    send_tick(aim, dt);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_reset_limits();
        send_tick(32'h0000_0000, 16'h8000);
        send_tick(32'h0004_0000, 16'hFFFF);
        send_tick(32'h0004_0000, 16'hFFFF);
        send_tick(32'h0004_0000, 16'hFFFF);
        send_tick(32'h0004_0000, 16'h0000);
        send_tick(32'hFFFC_0000, 16'h4000);
        send_tick(32'hFFFC_0000, 16'hC000);
    endtask

    task automatic test_extreme_limits();
        load_limits(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
        send_tick(32'h7FFF_FFFF, 16'hFFFF);
        send_tick(32'h7FFF_FFFF, 16'hFFFF);
        send_tick(32'h8000_0000, 16'hFFFF);
        send_tick(32'h8000_0000, 16'hFFFF);
        send_tick(32'h8000_0000, 16'hFFFF);
        load_limits(31'h0010_0000, 31'h0010_0000, 31'h0010_0000);
        send_tick(32'h03E8_0000, 16'h4000);
        send_tick(32'h03E8_0000, 16'h4000);
        // brake with zero decel, then hold speed at zero and drop tiny gains
        load_limits(31'h0010_0000, 31'd4, 31'd0);
        send_tick(32'h03E8_0000, 16'hFFFF);
        send_tick(32'h03E8_0000, 16'hFFFF);
        load_limits(31'd0, 31'd4, 31'd0);
        send_tick(32'h03E8_0000, 16'hFFFF);
        send_tick(32'h03E8_0000, 16'hFFFF);
    endtask

    task automatic test_register_index();
        load_limits(31'h0002_0000, 31'h0004_0000, 31'h0001_0000);
        cfg_write(REG_UNUSED, 31'h7FFFFFFF);
        cfg_we <= 1'b0;
        send_tick(32'hFFF0_0000, 16'h2000);
        send_tick(axis_pos, 16'h2000);
        send_tick(32'h0010_0000, 16'h2000);
    endtask

    task automatic test_output_stall();
        int k;
        drain();
        hold_off_len  = 200;
        sender_steady = 1'b1;
        for (k = 0; k < 12; k++)
            send_tick(nearby_target(), 16'($urandom_range(16'h0400, 16'h4000)));
        sender_steady = 1'b0;
        drain();
        run_profile(8);
    endtask

    task automatic test_random_profiles();
        int kinds[6];
        int p;
        kinds = '{0, 1, 0, 2, 0, 1};
        for (p = 0; p < 6; p++)
        begin
            if (kinds[p] == 0)
                load_limits(pick_limit(0), pick_limit(0), pick_limit(0));
            else
                load_limits(pick_limit(kinds[p]), pick_limit(kinds[p]),
                            pick_limit(kinds[p]));
            run_profile(60);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_limits();
        test_extreme_limits();
        test_register_index();
        test_output_stall();
        test_random_profiles();
        drain();
        repeat (60) @(posedge clk);
        if (expected_motion.size() != 0)
            failures++;
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
